// ===== hdl/sdc_pkg.sv =====
// Package: constants and month-end table for the serial date to calendar converter.
`timescale 1ns / 1ps

package sdc_pkg;

    localparam int unsigned DayW      = 17;
    localparam int unsigned FracW     = 32;
    localparam int unsigned DoyW      = 9;
    localparam int unsigned RemW      = 12;

    localparam logic [16:0] SerialMax = 17'd73415;
    localparam logic [16:0] DayMax    = 17'd73414;
    localparam logic [10:0] DaysCycle = 11'd1461;
    localparam logic [10:0] DaysLeap  = 11'd366;
    localparam logic [10:0] DaysYear  = 11'd365;
    localparam logic [11:0] BaseYear  = 12'd1900;

    localparam logic [16:0] SecsDay   = 17'd86400;
    localparam logic [16:0] SecsLast  = 17'd86399;
    localparam logic [11:0] SecsHour  = 12'd3600;
    localparam logic [5:0]  SecsMin   = 6'd60;

    // reciprocal multipliers: floor(x * M / 2^S) == x / C over the used range
    localparam logic [16:0] CycMul    = 17'd91868;
    localparam int unsigned CycShift  = 27;
    localparam logic [16:0] HourMul   = 17'd74566;
    localparam int unsigned HourShift = 28;
    localparam logic [12:0] MinMul    = 13'd4370;
    localparam int unsigned MinShift  = 18;

    localparam int unsigned NumEnds   = 11;

    function automatic logic [DoyW-1:0] month_end(input logic leap, input logic [3:0] idx);
        logic [DoyW-1:0] v;
        case (idx)
            4'd0:    v = 9'd31;
            4'd1:    v = 9'd59;
            4'd2:    v = 9'd90;
            4'd3:    v = 9'd120;
            4'd4:    v = 9'd151;
            4'd5:    v = 9'd181;
            4'd6:    v = 9'd212;
            4'd7:    v = 9'd243;
            4'd8:    v = 9'd273;
            4'd9:    v = 9'd304;
            4'd10:   v = 9'd334;
            default: v = 9'd511;
        endcase
        if (leap && idx != 4'd0 && idx < 4'd11) begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

// ===== hdl/serial_date_to_calendar.sv =====
// Top level: pipelined serial day/fraction to calendar date and time of day converter.
`timescale 1ns / 1ps

//  channel  | valid    | ready    | payload
//  ---------+----------+----------+-----------------------------------------------
//  input    | i_valid  | o_ready  | i_day_number, i_day_fraction
//  output   | o_valid  | i_ready  | o_year, o_month, o_day_of_month, o_hour,
//           |          |          | o_minute, o_second, o_range_flag
//
//  Seven register stages; a beat is accepted every cycle unless the output is
//  stalled and every stage is full. The time path runs through the day-fraction
//  scale and the hour and minute reciprocal multiplies, each followed by a register.
//  Each stage holds while the one after it is full and stalled; bubbles are
//  filled, so o_ready stays high while any stage is empty.
//  Reset (i_rst_n low, synchronous) clears the stage valid bits only.

module serial_date_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [16:0] i_day_number,
    input  logic [31:0] i_day_fraction,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic        o_range_flag
);

    localparam int unsigned NStg = 7;

    logic [NStg-1:0] r_v;
    logic [NStg-1:0] en;

    always_comb begin
        en[NStg-1] = !r_v[NStg-1] || i_ready;
        for (int k = NStg - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: clamp serial, zero-based day
    logic [16:0] r0_d, n0_d;
    logic        r0_flag, n0_flag;
    logic [31:0] r0_frac;

    always_comb begin
        n0_flag = 1'b0;
        n0_d    = i_day_number - 17'd1;
        if (i_day_number == 17'd0) begin
            n0_d    = 17'd0;
            n0_flag = 1'b1;
        end else if (i_day_number > sdc_pkg::SerialMax) begin
            n0_d    = sdc_pkg::DayMax;
            n0_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_d    <= n0_d;
            r0_flag <= n0_flag;
            r0_frac <= i_day_fraction;
        end
    end

    // stage 1: cycle quotient product, fraction times seconds per day
    logic [16:0] r1_d;
    logic        r1_flag;
    logic [33:0] r1_pq, n1_pq;
    logic [48:0] r1_ps, n1_ps;

    assign n1_pq = 34'(r0_d) * 34'(sdc_pkg::CycMul);
    assign n1_ps = 49'(r0_frac) * 49'(sdc_pkg::SecsDay);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_d    <= r0_d;
            r1_flag <= r0_flag;
            r1_pq   <= n1_pq;
            r1_ps   <= n1_ps;
        end
    end

    // stage 2: cycle and day in cycle; rounded, saturated seconds
    logic [5:0]  r2_cyc, n2_cyc;
    logic [10:0] r2_q, n2_q;
    logic [16:0] r2_secs, n2_secs;
    logic        r2_flag, n2_flag;
    logic [16:0] n2_qfull;
    logic [49:0] n2_sum;
    logic [17:0] n2_sraw;

    always_comb begin
        n2_cyc   = r1_pq[sdc_pkg::CycShift +: 6];
        n2_qfull = r1_d - 17'(17'(n2_cyc) * 17'(sdc_pkg::DaysCycle));
        n2_q     = n2_qfull[10:0];
        n2_sum   = 50'(r1_ps) + 50'h0_0000_8000_0000;
        n2_sraw  = n2_sum[49:32];
        n2_flag  = r1_flag;
        n2_secs  = n2_sraw[16:0];
        if (n2_sraw >= 18'(sdc_pkg::SecsDay)) begin
            n2_secs = sdc_pkg::SecsLast;
            n2_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_cyc  <= n2_cyc;
            r2_q    <= n2_q;
            r2_secs <= n2_secs;
            r2_flag <= n2_flag;
        end
    end

    // stage 3: year in cycle, day of year; hour product
    logic [5:0]  r3_cyc;
    logic [1:0]  r3_yic, n3_yic;
    logic [8:0]  r3_doy, n3_doy;
    logic [16:0] r3_secs;
    logic        r3_flag;
    logic [33:0] r3_ph, n3_ph;
    logic [10:0] n3_t;

    always_comb begin
        n3_t = r2_q - sdc_pkg::DaysLeap;
        if (r2_q < sdc_pkg::DaysLeap) begin
            n3_yic = 2'd0;
            n3_doy = 9'(r2_q + 11'd1);
        end else if (n3_t < sdc_pkg::DaysYear) begin
            n3_yic = 2'd1;
            n3_doy = 9'(n3_t + 11'd1);
        end else if (n3_t < 11'(2 * 365)) begin
            n3_yic = 2'd2;
            n3_doy = 9'(n3_t - 11'(365 - 1));
        end else begin
            n3_yic = 2'd3;
            n3_doy = 9'(n3_t - 11'(2 * 365 - 1));
        end
        n3_ph = 34'(r2_secs) * 34'(sdc_pkg::HourMul);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_cyc  <= r2_cyc;
            r3_yic  <= n3_yic;
            r3_doy  <= n3_doy;
            r3_secs <= r2_secs;
            r3_flag <= r2_flag;
            r3_ph   <= n3_ph;
        end
    end

    // stage 4: month lookup; hours and remaining seconds
    logic [5:0]  r4_cyc;
    logic [1:0]  r4_yic;
    logic [8:0]  r4_doy;
    logic [3:0]  r4_mon, n4_mon;
    logic [8:0]  r4_prev, n4_prev;
    logic [4:0]  r4_hh, n4_hh;
    logic [11:0] r4_rem, n4_rem;
    logic        r4_flag;
    logic [16:0] n4_rfull;
    logic [8:0]  n4_end;

    always_comb begin
        n4_mon  = 4'd1;
        n4_prev = 9'd0;
        n4_end  = 9'd0;
        for (int i = 0; i < sdc_pkg::NumEnds; i++) begin
            n4_end = sdc_pkg::month_end(r3_yic == 2'd0, 4'(i));
            if (r3_doy > n4_end) begin
                n4_mon  = 4'(i + 2);
                n4_prev = n4_end;
            end
        end
        n4_hh    = r3_ph[sdc_pkg::HourShift +: 5];
        n4_rfull = r3_secs - 17'(17'(n4_hh) * 17'(sdc_pkg::SecsHour));
        n4_rem   = n4_rfull[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_cyc  <= r3_cyc;
            r4_yic  <= r3_yic;
            r4_doy  <= r3_doy;
            r4_mon  <= n4_mon;
            r4_prev <= n4_prev;
            r4_hh   <= n4_hh;
            r4_rem  <= n4_rem;
            r4_flag <= r3_flag;
        end
    end

    // stage 5: year, day of month; minute product
    logic [11:0] r5_year, n5_year;
    logic [3:0]  r5_mon;
    logic [4:0]  r5_dom, n5_dom;
    logic [4:0]  r5_hh;
    logic [11:0] r5_rem;
    logic [24:0] r5_pm, n5_pm;
    logic        r5_flag;
    logic [8:0]  n5_dfull;

    always_comb begin
        n5_year  = sdc_pkg::BaseYear + {4'd0, r4_cyc, 2'b00} + 12'(r4_yic);
        n5_dfull = r4_doy - r4_prev;
        n5_dom   = n5_dfull[4:0];
        n5_pm    = 25'(r4_rem) * 25'(sdc_pkg::MinMul);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_year <= n5_year;
            r5_mon  <= r4_mon;
            r5_dom  <= n5_dom;
            r5_hh   <= r4_hh;
            r5_rem  <= r4_rem;
            r5_pm   <= n5_pm;
            r5_flag <= r4_flag;
        end
    end

    // stage 6: minutes and seconds, output register
    logic [5:0]  n6_mm;
    logic [11:0] n6_sfull;
    logic [11:0] r6_year;
    logic [3:0]  r6_mon;
    logic [4:0]  r6_dom;
    logic [4:0]  r6_hh;
    logic [5:0]  r6_mm;
    logic [5:0]  r6_ss;
    logic        r6_flag;

    always_comb begin
        n6_mm    = r5_pm[sdc_pkg::MinShift +: 6];
        n6_sfull = r5_rem - 12'(12'(n6_mm) * 12'(sdc_pkg::SecsMin));
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_year <= r5_year;
            r6_mon  <= r5_mon;
            r6_dom  <= r5_dom;
            r6_hh   <= r5_hh;
            r6_mm   <= n6_mm;
            r6_ss   <= n6_sfull[5:0];
            r6_flag <= r5_flag;
        end
    end

    assign o_year         = r6_year;
    assign o_month        = r6_mon;
    assign o_day_of_month = r6_dom;
    assign o_hour         = r6_hh;
    assign o_minute       = r6_mm;
    assign o_second       = r6_ss;
    assign o_range_flag   = r6_flag;

endmodule

// ===== tb/tb_serial_date_to_calendar.sv =====
// Testbench: serial date to calendar converter, directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module tb_serial_date_to_calendar;

    localparam int unsigned LastSerial = 73415;
    localparam int unsigned CycleDays  = 1461;
    localparam int unsigned LeapDays   = 366;
    localparam int unsigned CommonDays = 365;
    localparam int unsigned FirstYear  = 1900;
    localparam int unsigned DaySecs    = 86400;
    localparam int unsigned HoldLen    = 200;
    localparam int unsigned DrainPad   = 20;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  dom;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        flag;
    } t_calendar;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [16:0] i_day_number = '0;
    logic [31:0] i_day_fraction = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic        o_range_flag;

    t_calendar   cal_expected [$];
    int          mismatch_cnt = 0;
    int          send_idle_pct = 0;
    int          rcv_stall_pct = 0;
    logic        hold_on = 1'b0;
    int unsigned hold_cnt = 0;

    serial_date_to_calendar DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_day_number   (i_day_number),
        .i_day_fraction (i_day_fraction),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_range_flag   (o_range_flag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_calendar calc_calendar(input logic [16:0] day, input logic [31:0] frac);
        t_calendar   r;
        int unsigned serial;
        int unsigned d;
        int unsigned q;
        int unsigned yic;
        int unsigned doy;
        int unsigned mon;
        int unsigned mlen;
        int unsigned secs;
        logic [63:0] scaled;
        r.flag = 1'b0;
        serial = day;
        if (serial == 0) begin
            serial = 1;
            r.flag = 1'b1;
        end else if (serial > LastSerial) begin
            serial = LastSerial;
            r.flag = 1'b1;
        end
        d = serial - 1;
        q = d % CycleDays;
        if (q < LeapDays) begin
            yic = 0;
            doy = q + 1;
        end else begin
            yic = 1 + (q - LeapDays) / CommonDays;
            doy = (q - LeapDays) % CommonDays + 1;
        end
        r.year = 12'(FirstYear + 4 * (d / CycleDays) + yic);
        // walk month lengths; February gets 29 days in the first year of a cycle
        mon = 1;
        mlen = 31;
        while (doy > mlen) begin
            doy = doy - mlen;
            mon = mon + 1;
            if (mon == 2) begin
                mlen = (yic == 0) ? 29 : 28;
            end else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
                mlen = 30;
            end else begin
                mlen = 31;
            end
        end
        r.month = 4'(mon);
        r.dom = 5'(doy);
        scaled = {32'd0, frac} * 64'd86400 + 64'h0000_0000_8000_0000;
        secs = scaled[63:32];
        if (secs >= DaySecs) begin
            secs = DaySecs - 1;
            r.flag = 1'b1;
        end
        r.hour = 5'(secs / 3600);
        r.minute = 6'((secs % 3600) / 60);
        r.second = 6'(secs % 60);
        return r;
    endfunction

    task automatic send_date(input logic [16:0] day, input logic [31:0] frac);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_day_number <= day;
        i_day_fraction <= frac;
        do @(posedge i_clk); while (!o_ready);
        cal_expected.push_back(calc_calendar(day, frac));
    endtask

    task automatic send_random_date();
        int unsigned sel;
        int unsigned serial;
        int unsigned off;
        logic [31:0] frac;
        sel = $urandom_range(99);
        if (sel < 70) begin
            serial = $urandom_range(LastSerial, 1);
        end else if (sel < 85) begin
            // around year and cycle boundaries
            case ($urandom_range(5))
                0: off = 0;
                1: off = 365;
                2: off = 366;
                3: off = 731;
                4: off = 1096;
                default: off = 1460;
            endcase
            serial = $urandom_range(50) * CycleDays + off + $urandom_range(2);
        end else begin
            serial = $urandom_range(131071);
        end
        if ($urandom_range(99) < 80) begin
            frac = $urandom;
        end else begin
            frac = 32'hFFFF_FFFF - $urandom_range(60000);
        end
        send_date(17'(serial), frac);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        send_date(17'd0, 32'd0);
        send_date(17'd1, 32'd0);
        send_date(17'd59, 32'h8000_0000);
        send_date(17'd60, 32'h4000_0000);
        send_date(17'd61, 32'hC000_0000);
        send_date(17'd366, 32'hFFFF_9000);
        send_date(17'd367, 32'hFFFF_FFFF);
        send_date(17'd731, 32'h0000_C000);
        send_date(17'd1461, 32'h0000_6000);
        send_date(17'd1462, 32'h0000_5FFF);
        send_date(17'd2922, 32'd1);
        send_date(17'd73049, 32'h5555_5555);
        send_date(17'd73050, 32'hAAAA_AAAA);
        send_date(17'd73414, 32'h1234_5678);
        send_date(17'd73415, 32'hFFFF_FFFF);
        send_date(17'd73416, 32'd0);
        send_date(17'h1_FFFF, 32'hFFFF_FFFF);
        send_date(17'h1_5555, 32'h5555_5555);
        send_date(17'h0_AAAA, 32'hAAAA_AAAA);
        send_date(17'd43830, 32'hFFFF_9EC8);
        send_date(17'd36526, 32'h7FFF_FFFF);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
        repeat (count) send_random_date();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_on <= 1'b1;
        repeat (40) send_random_date();
        hold_on <= 1'b0;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (cal_expected.size() != 0) @(posedge i_clk);
        repeat (DrainPad) @(posedge i_clk);
    endtask

    // receiver: long hold on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_on && hold_cnt < HoldLen) begin
            i_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
            if (!hold_on) begin
                hold_cnt <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_calendar exp_cal;
        t_calendar got_cal;
        if (i_rst_n && o_valid && i_ready) begin
            got_cal = '{o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                        o_range_flag};
            if (cal_expected.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected beat: %0d-%0d-%0d %0d:%0d:%0d flag %0b",
                             o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                             o_range_flag);
                end
            end else begin
                exp_cal = cal_expected.pop_front();
                if (got_cal.year !== exp_cal.year || got_cal.month !== exp_cal.month
                        || got_cal.dom !== exp_cal.dom || got_cal.hour !== exp_cal.hour
                        || got_cal.minute !== exp_cal.minute
                        || got_cal.second !== exp_cal.second
                        || got_cal.flag !== exp_cal.flag) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: exp %0d-%0d-%0d %0d:%0d:%0d flag %0b,",
                                 exp_cal.year, exp_cal.month, exp_cal.dom, exp_cal.hour,
                                 exp_cal.minute, exp_cal.second, exp_cal.flag,
                                 " got %0d-%0d-%0d %0d:%0d:%0d flag %0b",
                                 got_cal.year, got_cal.month, got_cal.dom, got_cal.hour,
                                 got_cal.minute, got_cal.second, got_cal.flag);
                    end
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(240, 0, 0);
        test_random(240, 59, 0);
        test_random(240, 0, 59);
        test_backpressure();
        test_random(240, 23, 23);
        wait_results();
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
